>>> hw/rtl/mglu_pkg.sv
// Package for the gauge link update unit: lattice sizes, item types and arithmetic constants.
`timescale 1ns / 1ps
package mglu_pkg;

    localparam int TIME_SIZE  = 32;
    localparam int SPACE_SIZE = 32;
    localparam int DIRECTIONS = 2;
    localparam int ANGLE_BITS = 16;

    localparam int LINK_COUNT = TIME_SIZE * SPACE_SIZE * DIRECTIONS;
    localparam int ADDR_W     = $clog2(LINK_COUNT);
    localparam int KEEP_BITS  = (ANGLE_BITS > 16) ? 16 : ANGLE_BITS;
    localparam int DROP_BITS  = 16 - KEEP_BITS;
    localparam logic [15:0] PROP_MASK = 16'(16'hFFFF << DROP_BITS);

    localparam int TIME_W  = 5;
    localparam int SPACE_W = 5;
    localparam int DIR_W   = 1;

    localparam logic [30:0] PI_Q29     = 31'd1686629713;
    localparam logic [30:0] INVLN2_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;

    // Horner steps: cos uses steps 0..4, exp uses steps 5..12
    localparam logic [3:0] COS_LAST = 4'd4;
    localparam logic [3:0] EXP_FIRST = 4'd5;
    localparam logic [3:0] EXP_LAST = 4'd12;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [15:0]       prop;
        logic [15:0]       acc_rand;
    } t_work;

    function automatic logic [6:0] step_div(input logic [3:0] idx);
        logic [6:0] k;
        unique case (idx)
            4'd0:    k = 7'd90;
            4'd1:    k = 7'd56;
            4'd2:    k = 7'd30;
            4'd3:    k = 7'd12;
            4'd4:    k = 7'd2;
            4'd5:    k = 7'd8;
            4'd6:    k = 7'd7;
            4'd7:    k = 7'd6;
            4'd8:    k = 7'd5;
            4'd9:    k = 7'd4;
            4'd10:   k = 7'd3;
            4'd11:   k = 7'd2;
            4'd12:   k = 7'd1;
            default: k = 7'd1;
        endcase
        return k;
    endfunction

    // floor(2^32 / k), used with a one-step correction
    function automatic logic [32:0] step_recip(input logic [3:0] idx);
        logic [32:0] m;
        unique case (idx)
            4'd0:    m = 33'd47721858;
            4'd1:    m = 33'd76695844;
            4'd2:    m = 33'd143165576;
            4'd3:    m = 33'd357913941;
            4'd4:    m = 33'd2147483648;
            4'd5:    m = 33'd536870912;
            4'd6:    m = 33'd613566756;
            4'd7:    m = 33'd715827882;
            4'd8:    m = 33'd858993459;
            4'd9:    m = 33'd1073741824;
            4'd10:   m = 33'd1431655765;
            4'd11:   m = 33'd2147483648;
            4'd12:   m = 33'd4294967296;
            default: m = 33'd4294967296;
        endcase
        return m;
    endfunction

endpackage

>>> hw/rtl/mglu_in_if.sv
// Input channel: one link update request.
`timescale 1ns / 1ps
interface mglu_in_if;
    logic                          valid;
    logic                          ready;
    logic [mglu_pkg::TIME_W-1:0]   link_time;
    logic [mglu_pkg::SPACE_W-1:0]  link_space;
    logic [mglu_pkg::DIR_W-1:0]    link_dir;
    logic [15:0]                   proposal_random;
    logic [15:0]                   accept_random;

    modport source(output valid, link_time, link_space, link_dir, proposal_random,
                   accept_random, input ready);
    modport sink(input valid, link_time, link_space, link_dir, proposal_random,
                 accept_random, output ready);
endinterface

>>> hw/rtl/mglu_out_if.sv
// Output channel: kept angle and accept flag.
`timescale 1ns / 1ps
interface mglu_out_if;
    logic              valid;
    logic              ready;
    logic signed [15:0] kept_angle;
    logic              accepted;

    modport source(output valid, kept_angle, accepted, input ready);
    modport sink(input valid, kept_angle, accepted, output ready);
endinterface

>>> hw/rtl/mglu_cfg_if.sv
// Configuration write channel: coupling register.
`timescale 1ns / 1ps
interface mglu_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] coupling;

    modport source(output valid, coupling, input ready);
    modport sink(input valid, coupling, output ready);
endinterface

>>> hw/rtl/metropolis_gauge_link_update_unit.sv
// Top level of the gauge link Metropolis update unit.
`timescale 1ns / 1ps
// After reset the unit clears the angle memory to zero; up to three items are held
// meanwhile (front register and two-entry queue) but not processed. Once taken from the
// queue an item reaches the output register, when delta is not negative, through pop,
// memory read, two cosine evaluations on the shared multiply and constant-divide unit
// (fold, theta, theta squared, five Horner steps of multiply, divide and correction,
// rounding), delta, decision and write-back. When delta is negative the exponential
// adds the exponent split, eight Horner steps and the probability, or only the exponent
// check when the probability rounds to zero. One item is in the update engine at a time;
// a stalled output holds the engine in its write-back state. The queue and the output
// register let the input and output sides stall independently. The coupling register is
// always ready and should only be written while no item is in flight.
module metropolis_gauge_link_update_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mglu_in_if.sink     i_in,
    mglu_cfg_if.sink    i_cfg,
    mglu_out_if.source  o_out
);
    import mglu_pkg::*;

    logic  push;
    logic  push_ready;
    t_work front_work;
    logic  q_valid;
    t_work q_work;
    logic  q_pop;

    mglu_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push       (push),
        .o_work       (front_work),
        .i_push_ready (push_ready)
    );

    mglu_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_work       (front_work),
        .o_push_ready (push_ready),
        .o_valid      (q_valid),
        .o_work       (q_work),
        .i_pop        (q_pop)
    );

    mglu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_work  (q_work),
        .o_q_pop   (q_pop),
        .i_cfg     (i_cfg),
        .o_out     (o_out)
    );

endmodule

>>> hw/rtl/mglu_front.sv
// Front end: accepts items, forms link address and proposed angle.
`timescale 1ns / 1ps
module mglu_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    mglu_in_if.sink          i_in,
    output logic             o_push,
    output mglu_pkg::t_work  o_work,
    input  logic             i_push_ready
);
    import mglu_pkg::*;

    logic  r_valid;
    t_work r_work;
    t_work n_work;
    logic  take;

    assign i_in.ready = !r_valid || i_push_ready;
    assign take       = i_in.valid && i_in.ready;

    always_comb begin
        n_work.addr = ADDR_W'(((32'(i_in.link_time) % TIME_SIZE) * SPACE_SIZE
                               + (32'(i_in.link_space) % SPACE_SIZE)) * DIRECTIONS
                              + (32'(i_in.link_dir) % DIRECTIONS));
        // offset binary to two's complement, low bits dropped for narrow angles
        n_work.prop     = (i_in.proposal_random ^ 16'h8000) & PROP_MASK;
        n_work.acc_rand = i_in.accept_random;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_push_ready) begin
            r_valid <= 1'b0;
        end
        if (take) begin
            r_work <= n_work;
        end
    end

    assign o_push = r_valid;
    assign o_work = r_work;

endmodule

>>> hw/rtl/mglu_queue.sv
// Two-entry queue between front end and update engine.
`timescale 1ns / 1ps
module mglu_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mglu_pkg::t_work  i_work,
    output logic             o_push_ready,
    output logic             o_valid,
    output mglu_pkg::t_work  o_work,
    input  logic             i_pop
);
    import mglu_pkg::*;

    t_work      r_slot [2];
    logic [1:0] r_cnt;
    logic       r_wr;
    logic       r_rd;
    logic       do_push;
    logic       do_pop;

    assign o_push_ready = (r_cnt != 2'd2);
    assign o_valid      = (r_cnt != 2'd0);
    assign o_work       = r_slot[r_rd];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
        end else begin
            if (do_push) begin
                r_wr <= ~r_wr;
            end
            if (do_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
        if (do_push) begin
            r_slot[r_wr] <= i_work;
        end
    end

endmodule

>>> hw/rtl/mglu_back.sv
// Update engine: angle memory, shared Horner unit for cos and exp, accept decision.
`timescale 1ns / 1ps
module mglu_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  mglu_pkg::t_work  i_q_work,
    output logic             o_q_pop,
    mglu_cfg_if.sink         i_cfg,
    mglu_out_if.source       o_out
);
    import mglu_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_READ, S_FOLD, S_TH, S_T2, S_MUL, S_DIVM, S_DIVC,
        S_COSR, S_DELTA, S_DEC, S_Y, S_Z, S_PROB, S_WRITE
    } t_state;

    t_state             r_state;
    logic [ADDR_W-1:0]  r_clr_addr;
    t_work              r_item;
    logic [15:0]        mem [LINK_COUNT];
    logic [15:0]        r_rd_data;
    logic [15:0]        r_coupling;
    logic               r_second;
    logic [14:0]        r_m;
    logic               r_neg;
    logic [30:0]        r_th;
    logic [30:0]        r_base;
    logic signed [31:0] r_p;
    logic [30:0]        r_v;
    logic [31:0]        r_q0;
    logic [3:0]         r_step;
    logic               r_exp;
    logic signed [16:0] r_cos_new;
    logic signed [17:0] r_diff;
    logic signed [34:0] r_delta;
    logic [32:0]        r_y;
    logic               r_acc;
    logic               r_out_valid;
    logic [15:0]        r_out_kept;
    logic               r_out_acc;

    logic [15:0]        angle_sel;
    logic [16:0]        a_ext;
    logic [16:0]        a_abs;
    logic               fold_neg;
    logic [14:0]        fold_m;
    logic [45:0]        th_prod;
    logic [61:0]        t2_prod;
    logic [61:0]        mul_prod;
    logic [63:0]        div_prod;
    logic [6:0]         k;
    logic [31:0]        rem;
    logic [31:0]        q_fix;
    logic [31:0]        one;
    logic [31:0]        c_cl;
    logic [31:0]        c_rnd;
    logic signed [16:0] cos_val;
    logic [31:0]        x_mag;
    logic [62:0]        y_prod;
    logic [52:0]        z_prod;
    logic [4:0]         exp_sh;
    logic [30:0]        q_sh;
    logic [16:0]        prob;
    logic [15:0]        kept;
    logic               wr_go;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        angle_sel = r_second ? r_rd_data : r_item.prop;
        a_ext     = {angle_sel[15], angle_sel};
        a_abs     = angle_sel[15] ? (~a_ext + 17'd1) : a_ext;
        fold_neg  = a_abs > 17'd16384;
        fold_m    = fold_neg ? 15'(17'd32768 - a_abs) : a_abs[14:0];

        th_prod  = 46'(r_m) * 46'(PI_Q29);
        t2_prod  = 62'(r_th) * 62'(r_th);
        mul_prod = 62'(r_base) * 62'(r_p[30:0]);
        div_prod = 64'(r_v) * 64'(step_recip(r_step));

        k     = step_div(r_step);
        rem   = {1'b0, r_v} - 32'(r_q0 * 32'(k));
        q_fix = (rem >= 32'(k)) ? r_q0 + 32'd1 : r_q0;
        one   = r_exp ? 32'h4000_0000 : 32'h2000_0000;

        // clamp at zero, round Q29 to Q15
        c_cl    = r_p[31] ? 32'd0 : r_p;
        c_rnd   = c_cl + 32'd8192;
        cos_val = r_neg ? -$signed({1'b0, c_rnd[29:14]}) : $signed({1'b0, c_rnd[29:14]});

        x_mag  = 32'(-r_delta);
        y_prod = 63'(x_mag) * 63'(INVLN2_Q30);
        z_prod = 53'(r_y[22:0]) * 53'(LN2_Q30);

        exp_sh = 5'd13 + r_y[27:23];
        q_sh   = r_p[30:0] >> exp_sh;
        prob   = 17'((32'(q_sh) + 32'd1) >> 1);

        kept  = r_acc ? r_item.prop : r_rd_data;
        wr_go = (r_state == S_WRITE) && (!r_out_valid || o_out.ready);
    end

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;

    // angle store: registered read, clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (r_state == S_CLEAR) begin
            mem[r_clr_addr] <= 16'd0;
        end else if (wr_go) begin
            mem[r_item.addr] <= kept;
        end
        if (r_state == S_READ) begin
            r_rd_data <= mem[r_item.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_coupling  <= 16'd256;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_coupling <= i_cfg.coupling;
            end
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(LINK_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_item   <= i_q_work;
                        r_second <= 1'b0;
                        r_state  <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_FOLD;
                end
                S_FOLD: begin
                    r_m     <= fold_m;
                    r_neg   <= fold_neg;
                    r_state <= S_TH;
                end
                S_TH: begin
                    r_th    <= th_prod[45:15];
                    r_state <= S_T2;
                end
                S_T2: begin
                    r_base  <= t2_prod[59:29];
                    r_p     <= 32'sh2000_0000;
                    r_step  <= 4'd0;
                    r_exp   <= 1'b0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_v     <= r_exp ? mul_prod[60:30] : mul_prod[59:29];
                    r_state <= S_DIVM;
                end
                S_DIVM: begin
                    r_q0    <= div_prod[63:32];
                    r_state <= S_DIVC;
                end
                S_DIVC: begin
                    r_p <= $signed(one - q_fix);
                    if (!r_exp && r_step == COS_LAST) begin
                        r_state <= S_COSR;
                    end else if (r_exp && r_step == EXP_LAST) begin
                        r_state <= S_PROB;
                    end else begin
                        r_step  <= r_step + 4'd1;
                        r_state <= S_MUL;
                    end
                end
                S_COSR: begin
                    if (!r_second) begin
                        r_cos_new <= cos_val;
                        r_second  <= 1'b1;
                        r_state   <= S_FOLD;
                    end else begin
                        r_diff  <= 18'(r_cos_new) - 18'(cos_val);
                        r_state <= S_DELTA;
                    end
                end
                S_DELTA: begin
                    r_delta <= $signed({1'b0, r_coupling}) * 35'(r_diff);
                    r_state <= S_DEC;
                end
                S_DEC: begin
                    if (!r_delta[34]) begin
                        r_acc   <= 1'b1;
                        r_state <= S_WRITE;
                    end else begin
                        r_y     <= y_prod[62:30];
                        r_state <= S_Z;
                    end
                end
                S_Z: begin
                    // exponent of 17 or more rounds the probability to zero
                    if (r_y[32:23] >= 10'd17) begin
                        r_acc   <= (r_item.acc_rand == 16'd0);
                        r_state <= S_WRITE;
                    end else begin
                        r_base  <= 31'(z_prod[52:23]);
                        r_p     <= 32'sh4000_0000;
                        r_step  <= EXP_FIRST;
                        r_exp   <= 1'b1;
                        r_state <= S_MUL;
                    end
                end
                S_PROB: begin
                    r_acc   <= ({1'b0, r_item.acc_rand} <= prob);
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    if (wr_go) begin
                        r_out_valid <= 1'b1;
                        r_out_kept  <= kept;
                        r_out_acc   <= r_acc;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.kept_angle = $signed(r_out_kept);
    assign o_out.accepted   = r_out_acc;

    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !o_q_pop)
        else $error("item taken during clearing pass");

    a_write_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRITE && r_out_valid && !o_out.ready) |=> (r_state == S_WRITE))
        else $error("result overwritten while output stalled");

    a_write_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_go |=> (r_out_valid && r_out_kept == $past(kept) && r_out_acc == $past(r_acc)))
        else $error("written angle not reported");

endmodule

>>> tb/tb_metropolis_gauge_link_update_unit.sv
// Testbench for the gauge link Metropolis update unit: predicts each kept angle and accept flag.
`timescale 1ns / 1ps
module tb_metropolis_gauge_link_update_unit;
    import mglu_pkg::*;

    typedef struct packed {
        logic [TIME_W-1:0]  link_time;
        logic [SPACE_W-1:0] link_space;
        logic [DIR_W-1:0]   link_dir;
        logic [15:0]        proposal_random;
        logic [15:0]        accept_random;
    } t_request;

    typedef struct packed {
        logic signed [15:0] kept_angle;
        logic               accepted;
    } t_outcome;

    localparam longint PI_C     = 64'd1686629713;
    localparam longint INVLN2_C = 64'd1549082005;
    localparam longint LN2_C    = 64'd744261118;
    localparam int     LIMIT    = 2000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    mglu_in_if  in_ch();
    mglu_cfg_if cfg_ch();
    mglu_out_if out_ch();

    metropolis_gauge_link_update_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .i_cfg  (cfg_ch.sink),
        .o_out  (out_ch.source)
    );

    always #4 i_clk = ~i_clk;

    logic [15:0] angle_store [LINK_COUNT];
    logic [15:0] coupling_q;
    t_request    request_q[$];
    t_outcome    outcome_q[$];
    int          mismatches = 0;
    int          cycles = 0;
    int          gap_left = 0;
    int          stall_left = 0;
    bit          stim_done = 1'b0;
    bit          in_taken = 1'b0;

    function automatic longint cos_q15(logic [15:0] bits);
        longint a, m, th, t2, p, c, r;
        bit neg;
        a = longint'($signed(bits));
        m = a < 0 ? -a : a;
        neg = 1'b0;
        if (m > 16384) begin
            m = 32768 - m;
            neg = 1'b1;
        end
        th = (m * PI_C) >>> 15;
        t2 = (th * th) >>> 29;
        p = (64'sd1 << 29) - t2 / 90;
        p = (64'sd1 << 29) - ((t2 * p) >>> 29) / 56;
        p = (64'sd1 << 29) - ((t2 * p) >>> 29) / 30;
        p = (64'sd1 << 29) - ((t2 * p) >>> 29) / 12;
        c = (64'sd1 << 29) - ((t2 * p) >>> 29) / 2;
        if (c < 0) c = 0;
        r = (c + 8192) >>> 14;
        return neg ? -r : r;
    endfunction

    function automatic longint accept_prob_q16(longint x);
        longint unsigned y, n, f, z, q;
        y = (longint'(x) * INVLN2_C) >> 30;
        n = y >> 23;
        if (n >= 17) return 0;
        f = y & ((64'd1 << 23) - 1);
        z = (f * LN2_C) >> 23;
        q = 64'd1 << 30;
        for (int k = 8; k >= 1; k--)
            q = (64'd1 << 30) - ((z * q) >> 30) / k;
        return longint'(((q >> (13 + n)) + 1) >> 1);
    endfunction

    function automatic t_outcome update_link(t_request rq);
        int          addr;
        logic [15:0] old_a, prop;
        longint      delta;
        t_outcome    res;
        addr = (int'(rq.link_time) * SPACE_SIZE + int'(rq.link_space)) * DIRECTIONS
               + int'(rq.link_dir) % DIRECTIONS;
        old_a = angle_store[addr];
        prop = (rq.proposal_random ^ 16'h8000) & PROP_MASK;
        delta = longint'(coupling_q) * (cos_q15(prop) - cos_q15(old_a));
        if (delta >= 0)
            res.accepted = 1'b1;
        else
            res.accepted = longint'(rq.accept_random) <= accept_prob_q16(-delta);
        res.kept_angle = res.accepted ? prop : old_a;
        angle_store[addr] = res.kept_angle;
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    function automatic t_request rand_request();
        t_request rq;
        rq.link_time = TIME_W'($urandom_range(0, 3));
        rq.link_space = SPACE_W'($urandom_range(0, 3));
        if ($urandom_range(0, 3) == 0) begin
            rq.link_time = TIME_W'($urandom);
            rq.link_space = SPACE_W'($urandom);
        end
        rq.link_dir = DIR_W'($urandom);
        rq.proposal_random = 16'($urandom);
        rq.accept_random = 16'($urandom);
        return rq;
    endfunction

    // marks an input item taken at the last rising edge
    always @(posedge i_clk) begin
        in_taken <= in_ch.valid && in_ch.ready;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (in_ch.valid && !in_taken) begin
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            in_ch.valid <= 1'b0;
        end else if (request_q.size() > 0) begin
            t_request rq;
            rq = request_q.pop_front();
            {in_ch.link_time, in_ch.link_space, in_ch.link_dir, in_ch.proposal_random,
             in_ch.accept_random} <= rq;
            in_ch.valid <= 1'b1;
            outcome_q.push_back(update_link(rq));
            gap_left <= pick_gap();
        end else begin
            in_ch.valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (outcome_q.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10) $display("unexpected item %0d/%0b",
                                              out_ch.kept_angle, out_ch.accepted);
            end else begin
                t_outcome exp_o;
                exp_o = outcome_q.pop_front();
                if (exp_o.kept_angle !== out_ch.kept_angle
                    || exp_o.accepted !== out_ch.accepted) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: expected %0d/%0b actual %0d/%0b",
                                 exp_o.kept_angle, exp_o.accepted,
                                 out_ch.kept_angle, out_ch.accepted);
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic write_coupling(logic [15:0] v);
        @(negedge i_clk);
        cfg_ch.coupling <= v;
        cfg_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        coupling_q = v;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic run_phase(int count, bit directed);
        t_request rq;
        if (directed) begin
            rq = '0; rq.proposal_random = 16'h8000; request_q.push_back(rq);
            rq = '1; request_q.push_back(rq);
            rq = '0; rq.proposal_random = 16'h0000; rq.accept_random = 16'hFFFF;
            request_q.push_back(rq);
            rq.accept_random = 16'h0000; request_q.push_back(rq);
            rq.proposal_random = 16'hC000; request_q.push_back(rq);
            rq.proposal_random = 16'h4000; rq.link_dir = 1'b1; request_q.push_back(rq);
            rq.link_time = 5'd31; rq.link_space = 5'd31; rq.proposal_random = 16'h7FFF;
            rq.accept_random = 16'h8000; request_q.push_back(rq);
            for (int i = 0; i < 12; i++) request_q.push_back(rand_request());
        end
        for (int i = 0; i < count; i++) request_q.push_back(rand_request());
        while (request_q.size() > 0 || in_ch.valid || outcome_q.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        logic [15:0] settings [6];
        settings = '{16'd0, 16'hFFFF, 16'd1, 16'd4096, 16'd64, 16'd700};
        in_ch.valid = 1'b0;
        in_ch.link_time = '0;
        in_ch.link_space = '0;
        in_ch.link_dir = '0;
        in_ch.proposal_random = '0;
        in_ch.accept_random = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.coupling = '0;
        out_ch.ready = 1'b0;
        coupling_q = 16'd256;
        foreach (angle_store[i]) angle_store[i] = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        run_phase(150, 1'b1);
        foreach (settings[s]) begin
            write_coupling(settings[s]);
            run_phase(s == 0 ? 60 : 120, s == 1);
        end
        if (mismatches == 0 && outcome_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
